FILE: rtl/gbs_pkg.sv
// Package for the greedy box suppressor: sizes, configuration register
// indexes, controller states, the kept-store entry and the control bundles.
// No dependencies.
package gbs_pkg;

  localparam int MAX_KEPT = 64;
  localparam int MAX_BOXES = 4096;
  localparam int KEPT_AW = $clog2(MAX_KEPT);
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int POS_W = 12;
  localparam logic [POS_W-1:0] POS_LIMIT =
    (MAX_BOXES - 1 < 4095) ? POS_W'(MAX_BOXES - 1) : POS_W'(4095);

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = 1'b1;
  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [16:0] right;
    logic signed [16:0] bottom;
    logic [29:0]        area;
    logic [7:0]         cls;
  } entry_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic pipe_busy;
  } status_t;

endpackage

FILE: rtl/gbs_ctrl.sv
// Controller of the greedy box suppressor: steps each box through the scan
// of the kept store, the pipeline drain and the final decision.
// Depends on gbs_pkg.
module gbs_ctrl
  import gbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd.issue = !status.scan_end;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/gbs_datapath.sv
// Datapath of the greedy box suppressor: configuration registers, kept-box
// store, the overlap test pipeline and the result registers.
// Depends on gbs_pkg.
module gbs_datapath
  import gbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic signed [15:0]    box_left,
  input  logic signed [15:0]    box_top,
  input  logic [14:0]           box_width,
  input  logic [14:0]           box_height,
  input  logic [7:0]            class_label,
  input  logic                  frame_start,
  output logic                  done,
  output logic                  keep,
  output logic [11:0]           box_index,
  output logic                  store_overflow
);

  logic [15:0]      iou_threshold;
  logic             class_agnostic;

  entry_t           mem [MAX_KEPT];
  entry_t           rd_data;
  entry_t           cand;
  entry_t           cand_next;

  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] addr;
  logic [POS_W-1:0] frame_position;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] idx;

  logic             v0, v1, v2, v3, v4;
  logic [14:0]      iw1, ih1;
  logic [29:0]      karea1, karea2;
  logic [29:0]      inter2, inter3, inter4;
  logic [30:0]      uni3;
  logic [46:0]      prod4;
  logic             suppress;

  logic signed [15:0] lo_x, lo_y;
  logic signed [16:0] hi_x, hi_y;
  logic signed [17:0] diff_x, diff_y;
  logic               match;
  logic               survive;
  logic               store_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_threshold <= IOU_THRESHOLD_RESET;
      class_agnostic <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IOU_THRESHOLD: iou_threshold <= cfg_data;
        REG_CLASS_AGNOSTIC: class_agnostic <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cand_next.left = box_left;
    cand_next.top = box_top;
    cand_next.right = {box_left[15], box_left} + {2'b00, box_width};
    cand_next.bottom = {box_top[15], box_top} + {2'b00, box_height};
    cand_next.area = 30'(box_width) * 30'(box_height);
    cand_next.cls = class_label;
  end

  always_comb begin
    pos_cur = frame_start ? '0 : frame_position;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand <= cand_next;
      idx <= pos_cur;
    end
  end

  assign survive = !suppress;
  assign store_ok = survive && (kept_count < CNT_W'(MAX_KEPT));

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      frame_position <= '0;
      addr <= '0;
    end else begin
      if (cmd.load) begin
        addr <= '0;
        if (frame_start) kept_count <= '0;
        frame_position <= (pos_cur < POS_LIMIT) ? pos_cur + POS_W'(1) : pos_cur;
      end else if (cmd.issue) begin
        addr <= addr + CNT_W'(1);
      end
      if (cmd.finish && store_ok) kept_count <= kept_count + CNT_W'(1);
    end
  end

  assign status.scan_end = (addr >= kept_count);
  assign status.pipe_busy = v0 | v1 | v2 | v3 | v4;

  always_ff @(posedge clk) begin
    if (cmd.finish && store_ok) mem[kept_count[KEPT_AW-1:0]] <= cand;
    if (cmd.issue) rd_data <= mem[addr[KEPT_AW-1:0]];
  end

  always_comb begin
    lo_x = (cand.left > rd_data.left) ? cand.left : rd_data.left;
    lo_y = (cand.top > rd_data.top) ? cand.top : rd_data.top;
    hi_x = (cand.right < rd_data.right) ? cand.right : rd_data.right;
    hi_y = (cand.bottom < rd_data.bottom) ? cand.bottom : rd_data.bottom;
    diff_x = {hi_x[16], hi_x} - {{2{lo_x[15]}}, lo_x};
    diff_y = {hi_y[16], hi_y} - {{2{lo_y[15]}}, lo_y};
    match = class_agnostic || (rd_data.cls == cand.cls);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v0 <= cmd.issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Unless class_agnostic is set, a kept box of another class yields zero overlap, which never suppresses.
  always_ff @(posedge clk) begin
    iw1 <= (match && !diff_x[17] && diff_x != '0) ? diff_x[14:0] : '0;
    ih1 <= (match && !diff_y[17] && diff_y != '0) ? diff_y[14:0] : '0;
    karea1 <= rd_data.area;
    inter2 <= 30'(iw1) * 30'(ih1);
    karea2 <= karea1;
    uni3 <= 31'(cand.area) + 31'(karea2) - 31'(inter2);
    inter3 <= inter2;
    prod4 <= 47'(iou_threshold) * 47'(uni3);
    inter4 <= inter3;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      suppress <= 1'b0;
    end else if (v4 && ({1'b0, inter4, 16'h0000} > prod4)) begin
      suppress <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      keep <= store_ok;
      store_overflow <= survive && !store_ok;
      box_index <= 12'(idx);
    end
  end

endmodule

FILE: rtl/greedy_box_suppressor.sv
// Top level of the greedy box suppressor: joins the controller and the
// datapath. Depends on gbs_pkg, gbs_ctrl and gbs_datapath.
//
//   Channel   Handshake              Payload
//   input     start & !busy          box_left, box_top, box_width, box_height,
//                                    class_label, frame_start
//   result    done (one cycle)       keep, box_index, store_overflow
//   config    cfg_write              cfg_index, cfg_data
//
// A box is tested against every box kept so far in the frame before its done
// pulse: the kept store is read one entry per cycle and each read passes a
// five-stage overlap pipeline.
// busy is high from the cycle after acceptance until the result is decided;
// the next box may be started in the cycle done is high.
// rst is synchronous; it clears the store count, the frame position and the
// configuration registers. Results cannot be held off by the receiver.
module greedy_box_suppressor
  import gbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [15:0]    box_left,
  input  logic signed [15:0]    box_top,
  input  logic [14:0]           box_width,
  input  logic [14:0]           box_height,
  input  logic [7:0]            class_label,
  input  logic                  frame_start,
  output logic                  done,
  output logic                  keep,
  output logic [11:0]           box_index,
  output logic                  store_overflow,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  gbs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  gbs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_width      (box_width),
    .box_height     (box_height),
    .class_label    (class_label),
    .frame_start    (frame_start),
    .done           (done),
    .keep           (keep),
    .box_index      (box_index),
    .store_overflow (store_overflow)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for greedy_box_suppressor: drives box transactions,
// predicts keep, box_index and store_overflow for each box and checks every result.
// Depends on gbs_pkg and the greedy_box_suppressor RTL.
module testbench;
  import gbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [7:0]         cls;
    logic               fstart;
  } box_t;

  typedef struct {
    logic        keep;
    logic [11:0] index;
    logic        overflow;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic signed [15:0]    box_left = '0;
  logic signed [15:0]    box_top = '0;
  logic [14:0]           box_width = '0;
  logic [14:0]           box_height = '0;
  logic [7:0]            class_label = '0;
  logic                  frame_start = 1'b0;
  logic                  done;
  logic                  keep;
  logic [11:0]           box_index;
  logic                  store_overflow;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_t     box_q[$];
  verdict_t verdict_q[$];
  box_t     next_box;
  box_t     seen_box;
  verdict_t want;
  logic     taken = 1'b0;
  logic     box_pending = 1'b0;
  int       gap_left = 0;
  int       no_gap_run = 0;
  int       roll;
  int       idle_cycles = 0;
  int       mismatch_count = 0;

  // Predictor state: kept boxes of the current frame and the register copies.
  int          kept_left[MAX_KEPT];
  int          kept_top[MAX_KEPT];
  int          kept_right[MAX_KEPT];
  int          kept_bottom[MAX_KEPT];
  longint      kept_area[MAX_KEPT];
  logic [7:0]  kept_cls[MAX_KEPT];
  int          kept_n = 0;
  int          frame_pos = 0;
  logic [15:0] iou_limit = IOU_THRESHOLD_RESET;
  logic        agnostic = 1'b0;

  greedy_box_suppressor i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .box_left(box_left),
    .box_top(box_top),
    .box_width(box_width),
    .box_height(box_height),
    .class_label(class_label),
    .frame_start(frame_start),
    .done(done),
    .keep(keep),
    .box_index(box_index),
    .store_overflow(store_overflow),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic verdict_t judge_box(box_t b);
    int       cl, ct, cr, cb, ow, oh;
    longint   area, inter, uni;
    bit       survive;
    verdict_t v;
    if (b.fstart) begin
      kept_n = 0;
      frame_pos = 0;
    end
    cl = b.left;
    ct = b.top;
    cr = cl + int'({17'd0, b.width});
    cb = ct + int'({17'd0, b.height});
    area = longint'({17'd0, b.width}) * longint'({17'd0, b.height});
    survive = 1'b1;
    for (int k = 0; k < kept_n; k++) begin
      if (agnostic || kept_cls[k] == b.cls) begin
        ow = ((cr < kept_right[k]) ? cr : kept_right[k]) -
             ((cl > kept_left[k]) ? cl : kept_left[k]);
        oh = ((cb < kept_bottom[k]) ? cb : kept_bottom[k]) -
             ((ct > kept_top[k]) ? ct : kept_top[k]);
        inter = (ow > 0 && oh > 0) ? longint'(ow) * longint'(oh) : 64'sd0;
        uni = area + kept_area[k] - inter;
        if ((inter << 16) > longint'({48'd0, iou_limit}) * uni)
          survive = 1'b0;
      end
    end
    v.keep = 1'b0;
    v.overflow = 1'b0;
    if (survive) begin
      if (kept_n < MAX_KEPT) begin
        kept_left[kept_n] = cl;
        kept_top[kept_n] = ct;
        kept_right[kept_n] = cr;
        kept_bottom[kept_n] = cb;
        kept_area[kept_n] = area;
        kept_cls[kept_n] = b.cls;
        kept_n++;
        v.keep = 1'b1;
      end else begin
        v.overflow = 1'b1;
      end
    end
    v.index = frame_pos[11:0];
    if (frame_pos < int'(POS_LIMIT))
      frame_pos++;
    return v;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_box(int l, int t, int w, int h, int c, bit fs);
    box_t b;
    b.left = 16'(l);
    b.top = 16'(t);
    b.width = 15'(w);
    b.height = 15'(h);
    b.cls = 8'(c);
    b.fstart = fs;
    box_q = {box_q, b};
  endtask

  task automatic set_config(logic [15:0] thr, logic agn);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IOU_THRESHOLD;
    cfg_data <= thr;
    @(negedge clk);
    cfg_index <= REG_CLASS_AGNOSTIC;
    cfg_data <= CFG_DATA_W'(agn);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (box_q.size() != 0 || box_pending || verdict_q.size() != 0);
  endtask

  // Frames of clustered boxes with random content, with some noise boxes mixed in.
  task automatic queue_traffic(int count);
    int   made, frame_len, cx, cy, classes, spread;
    box_t b;
    made = 0;
    while (made < count) begin
      frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 110) : $urandom_range(3, 40);
      cx = $urandom_range(0, 65535) - 32768;
      cy = $urandom_range(0, 65535) - 32768;
      classes = (frame_len > 64) ? $urandom_range(4, 12) : $urandom_range(1, 4);
      spread = $urandom_range(0, 1) ? 64 : 2048;
      for (int i = 0; i < frame_len && made < count; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          b.left = 16'($urandom);
          b.top = 16'($urandom);
          b.width = 15'($urandom);
          b.height = 15'($urandom);
          b.cls = 8'($urandom);
          b.fstart = 1'($urandom);
        end else begin
          b.left = 16'(cx + int'($urandom_range(0, 2 * spread)) - spread);
          b.top = 16'(cy + int'($urandom_range(0, 2 * spread)) - spread);
          b.width = ($urandom_range(0, 19) == 0) ? 15'($urandom_range(0, 32767))
                                                 : 15'($urandom_range(0, 400));
          b.height = ($urandom_range(0, 19) == 0) ? 15'($urandom_range(0, 32767))
                                                  : 15'($urandom_range(0, 400));
          b.cls = 8'($urandom_range(0, classes - 1));
          b.fstart = (i == 0) && ($urandom_range(0, 9) != 0);
        end
        box_q = {box_q, b};
        made++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (taken)
      box_pending = 1'b0;
    if (!rst && !box_pending) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (box_q.size() != 0) begin
        next_box = box_q.pop_front();
        box_pending = 1'b1;
        start <= 1'b1;
        box_left <= next_box.left;
        box_top <= next_box.top;
        box_width <= next_box.width;
        box_height <= next_box.height;
        class_label <= next_box.cls;
        frame_start <= next_box.fstart;
        if (no_gap_run > 0) begin
          no_gap_run--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 5) begin
            no_gap_run = $urandom_range(20, 60);
            gap_left = 0;
          end else if (roll < 50) begin
            gap_left = 0;
          end else if (roll < 92) begin
            gap_left = $urandom_range(1, 4);
          end else begin
            gap_left = $urandom_range(10, 100);
          end
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    taken <= !rst && start && !busy;
    if (rst) begin
      kept_n = 0;
      frame_pos = 0;
      iou_limit = IOU_THRESHOLD_RESET;
      agnostic = 1'b0;
      idle_cycles <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IOU_THRESHOLD: iou_limit = cfg_data[15:0];
          REG_CLASS_AGNOSTIC: agnostic = cfg_data[0];
          default: ;
        endcase
      end
      if (done) begin
        if (verdict_q.size() == 0) begin
          flag_error("result transaction with no box outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (keep !== want.keep)
            flag_error($sformatf("keep %b, expected %b", keep, want.keep));
          if (box_index !== want.index)
            flag_error($sformatf("box_index %0d, expected %0d", box_index, want.index));
          if (store_overflow !== want.overflow)
            flag_error($sformatf("store_overflow %b, expected %b (box_index %0d)",
                                 store_overflow, want.overflow, want.index));
        end
      end
      if (start && !busy) begin
        seen_box.left = box_left;
        seen_box.top = box_top;
        seen_box.width = box_width;
        seen_box.height = box_height;
        seen_box.cls = class_label;
        seen_box.fstart = frame_start;
        verdict_q = {verdict_q, judge_box(seen_box)};
      end
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed transactions at the reset configuration, starting without a frame start.
    push_box(-32768, -32768, 32767, 32767, 255, 1'b0);
    push_box(-32768, -32768, 32767, 32767, 255, 1'b0);
    push_box(-32768, -32768, 32767, 32767, 0, 1'b0);
    push_box(100, 100, 0, 0, 7, 1'b0);
    push_box(100, 100, 0, 0, 7, 1'b0);
    push_box(32767, 32767, 32767, 32767, 1, 1'b0);
    push_box(32000, 32000, 1000, 1000, 1, 1'b0);
    push_box(0, 0, 16, 16, 2, 1'b0);
    push_box(16, 0, 16, 16, 2, 1'b0);
    push_box(4, 0, 16, 16, 2, 1'b0);
    push_box(-32768, -32768, 32767, 32767, 255, 1'b1);
    push_box(0, 0, 32767, 0, 128, 1'b1);
    wait_drained();

    set_config(IOU_THRESHOLD_RESET, 1'b1);
    push_box(-100, -100, 200, 200, 3, 1'b1);
    push_box(-100, -100, 200, 200, 4, 1'b0);
    push_box(-90, -100, 200, 200, 200, 1'b0);
    wait_drained();

    set_config(IOU_THRESHOLD_RESET, 1'b0);
    queue_traffic(350);
    wait_drained();
    set_config(16'hFFFF, 1'b0);
    queue_traffic(350);
    wait_drained();
    set_config(16'h0000, 1'b1);
    queue_traffic(350);
    wait_drained();
    set_config(16'($urandom), 1'($urandom));
    queue_traffic(350);
    wait_drained();
    set_config(16'h8000, 1'b1);
    queue_traffic(350);
    wait_drained();

    repeat (MAX_KEPT + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
